// ----- sv/ccwe_pkg.sv -----
package ccwe_pkg;

  // Word geometry: eight bytes per data word, byte count saturates here
  localparam int unsigned BytesPerWord = 8;
  localparam int unsigned CountW       = 4;
  localparam logic [CountW-1:0] MaxCount = CountW'(BytesPerWord);

  // Polynomial select codes
  localparam logic PolyCrc32  = 1'b0;
  localparam logic PolyCrc32c = 1'b1;

  // Bit-reflected polynomials (0x04C11DB7 and 0x1EDC6F41)
  localparam logic [31:0] RPolyCrc32  = 32'hEDB8_8320;
  localparam logic [31:0] RPolyCrc32c = 32'h82F6_3B78;

  // Running register value after reset
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // Lane control handed to the update network
  typedef struct packed {
    logic              poly_sel;
    logic [CountW-1:0] count;
  } ccwe_ctrl_t;

  // One byte through the reflected CRC, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  byte_in,
                                           input logic [31:0] rpoly);
    logic [31:0] c;
    c = crc_in ^ {24'h0, byte_in};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/ccwe_xor_net.sv -----
module ccwe_xor_net
  import ccwe_pkg::*;
(
  input  logic [31:0]               crc_i,
  input  logic [8*BytesPerWord-1:0] data_i,
  input  ccwe_ctrl_t                ctrl_i,
  output logic [31:0]               crc_o
);

  logic [31:0]       rpoly;
  logic [CountW-1:0] cnt_sat;
  logic [31:0]       chain [BytesPerWord+1];

  // Polynomial pick and count saturation
  assign rpoly   = (ctrl_i.poly_sel == PolyCrc32c) ? RPolyCrc32c : RPolyCrc32;
  assign cnt_sat = (ctrl_i.count > MaxCount) ? MaxCount : ctrl_i.count;

  assign chain[0] = crc_i;

  // One lane per byte; lanes beyond the count pass the value through
  for (genvar k = 0; k < BytesPerWord; k++) begin : g_lane
    always_comb begin
      if (CountW'(k) < cnt_sat) begin
        chain[k+1] = crc_byte(chain[k], data_i[8*k +: 8], rpoly);
      end else begin
        chain[k+1] = chain[k];
      end
    end
  end

  assign crc_o = chain[BytesPerWord];

endmodule

// ----- sv/crc32_crc32c_word_engine_top.sv -----
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------------------------
// in       | input     | in_valid_i / in_stall_o   | first_word_i seed_i data_word_i
//          |           |                           | byte_count_i last_word_i
// out      | output    | out_valid_o / out_stall_i | crc_value_o is_final_o
// cfg      | input     | cfg_we_i                  | cfg_wdata_i (poly select)
//
// One word per cycle while in_stall_o is low; each result is registered in the output register, or in the skid entry.
// The byte lanes and running register update form a single XOR pass per word.
// Reset sets the running CRC to all ones and selects CRC-32.
// A two-entry output buffer lets a word be taken while one result waits;
// in_stall_o rises only when both entries are full.
module crc32_crc32c_word_engine_top
  import ccwe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_word_i,
  input  logic [31:0] seed_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] crc_value_o,
  output logic        is_final_o
);

  logic        poly_q;
  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_start;
  ccwe_ctrl_t  ctrl;

  logic        out_valid_q, skid_valid_q;
  logic [31:0] out_crc_q, skid_crc_q;
  logic        out_final_q, skid_final_q;

  logic        in_xfer, out_xfer, out_free;

  // Handshakes
  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i & ~skid_valid_q;
  assign out_xfer   = out_valid_q & ~out_stall_i;
  assign out_free   = ~out_valid_q | out_xfer;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyCrc32;
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i;
    end
  end

  // Seed load then byte lanes
  assign crc_start     = first_word_i ? ~seed_i : crc_q;
  assign ctrl.poly_sel = poly_q;
  assign ctrl.count    = byte_count_i;

  ccwe_xor_net u_xor_net (
    .crc_i  (crc_start),
    .data_i (data_word_i),
    .ctrl_i (ctrl),
    .crc_o  (crc_d)
  );

  // Running CRC register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else if (in_xfer) begin
      crc_q <= crc_d;
    end
  end

  // Output register and skid entry: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | in_xfer;
      skid_valid_q <= 1'b0;
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output register and skid entry: payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_crc_q   <= skid_crc_q;
        out_final_q <= skid_final_q;
      end else if (in_xfer) begin
        out_crc_q   <= ~crc_d;
        out_final_q <= last_word_i;
      end
    end else if (in_xfer) begin
      skid_crc_q   <= ~crc_d;
      skid_final_q <= last_word_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_crc_q;
  assign is_final_o  = out_final_q;

  // Checks
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && in_xfer) |=> skid_valid_q)
    else $error("transfer lost while output stalled");

  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_free && !skid_valid_q && in_xfer) |=> (out_crc_q == ~crc_q))
    else $error("result does not match running register");

  a_seed_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && first_word_i && byte_count_i == '0) |=> (crc_q == ~$past(seed_i)))
    else $error("seed not loaded on empty first word");

endmodule
